// ===== hdl/rpn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the RPN stack evaluator.
package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int MAG_W       = DATA_W + FRAC_W;
  localparam int DEPTH_W     = 8;
  localparam int ACT_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MUL    = 3'd3,
    ACT_DIV    = 3'd4,
    ACT_FINISH = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ZERODIV = 2'd2,
    ST_BADOP   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WAIT_L,
    S_POP_L,
    S_MUL,
    S_DIV_INIT,
    S_DIV_STEP,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] number;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] value;
    logic [DEPTH_W-1:0]       depth;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic pop_r;
    logic pop_l;
    logic mul;
    logic div_init;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             r_zero;
    logic             div_last;
    logic             out_free;
  } dp_status_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^(DATA_W-1).
  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    mag_of = v[DATA_W-1] ? (~v + 1'b1) : v;
  endfunction

  // Applies a sign to a magnitude and saturates to the signed word range.
  function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
    logic [DATA_W-1:0] res;
    if (neg) begin
      if (mag >= MAG_W'(MIN_NEG)) begin
        res = MIN_NEG;
      end else begin
        res = ~mag[DATA_W-1:0] + 1'b1;
      end
    end else begin
      if (mag > MAG_W'(MAX_POS)) begin
        res = MAX_POS;
      end else begin
        res = mag[DATA_W-1:0];
      end
    end
    sat_mag = res;
  endfunction

  // Saturates a sign-extended sum that carries one guard bit.
  function automatic logic [DATA_W-1:0] sat_sum(input logic [DATA_W:0] s);
    logic [DATA_W-1:0] res;
    if (s[DATA_W] != s[DATA_W-1]) begin
      res = s[DATA_W] ? MIN_NEG : MAX_POS;
    end else begin
      res = s[DATA_W-1:0];
    end
    sat_sum = res;
  endfunction

endpackage

// ===== hdl/rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Top level of the RPN stack evaluator: controller plus datapath.
// Each input transfer carries one reverse Polish token in signed Q16.16 and
// yields exactly one result transfer with status, new stack top and depth.
// The block works on one token at a time. Push, finish and invalid tokens go
// from decode to commit. Add and subtract pop the right operand, wait for the
// read, pop the left one and commit; multiply adds a product step before the
// commit, a zero divisor commits without taking the left operand, and divide
// runs the radix-2 divider, one quotient bit per cycle. The next token is
// taken in the cycle after the commit, while the previous result may still be
// held in the output register; a commit waits while a held result is stalled.
// The stack lives in a single-port-write memory with a registered read of the
// top entry, and needs no clearing after reset.
module rpn_stack_evaluator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rpn_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rpn_pkg::out_item_t out_data_o
);

  rpn_pkg::dp_cmd_t    cmd;
  rpn_pkg::dp_status_t st;

  rpn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rpn_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hdl/rpn_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine for the RPN stack evaluator.
module rpn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rpn_pkg::dp_status_t st_i,
  output rpn_pkg::dp_cmd_t    cmd_o
);

  rpn_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = rpn_pkg::S_DECODE;
        end
      end
      rpn_pkg::S_DECODE: begin
        if (st_i.action inside {[rpn_pkg::ACT_ADD:rpn_pkg::ACT_DIV]}) begin
          state_d = rpn_pkg::S_WAIT_L;
        end else begin
          state_d = rpn_pkg::S_COMMIT;
        end
      end
      rpn_pkg::S_WAIT_L: begin
        state_d = rpn_pkg::S_POP_L;
      end
      rpn_pkg::S_POP_L: begin
        case (st_i.action)
          rpn_pkg::ACT_MUL: state_d = rpn_pkg::S_MUL;
          rpn_pkg::ACT_DIV: begin
            state_d = st_i.r_zero ? rpn_pkg::S_COMMIT : rpn_pkg::S_DIV_INIT;
          end
          default: state_d = rpn_pkg::S_COMMIT;
        endcase
      end
      rpn_pkg::S_MUL: begin
        state_d = rpn_pkg::S_COMMIT;
      end
      rpn_pkg::S_DIV_INIT: begin
        state_d = rpn_pkg::S_DIV_STEP;
      end
      rpn_pkg::S_DIV_STEP: begin
        if (st_i.div_last) begin
          state_d = rpn_pkg::S_COMMIT;
        end
      end
      rpn_pkg::S_COMMIT: begin
        if (st_i.out_free) begin
          state_d = rpn_pkg::S_IDLE;
        end
      end
      default: state_d = rpn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      rpn_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      rpn_pkg::S_DECODE: begin
        cmd_o.pop_r = st_i.action inside {[rpn_pkg::ACT_ADD:rpn_pkg::ACT_DIV]};
      end
      rpn_pkg::S_POP_L: begin
        // A zero divisor ends the operation without taking the left operand.
        cmd_o.pop_l = !(st_i.action == rpn_pkg::ACT_DIV && st_i.r_zero);
      end
      rpn_pkg::S_MUL:      cmd_o.mul      = 1'b1;
      rpn_pkg::S_DIV_INIT: cmd_o.div_init = 1'b1;
      rpn_pkg::S_DIV_STEP: cmd_o.div_step = 1'b1;
      rpn_pkg::S_COMMIT:   cmd_o.commit   = st_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ===== hdl/rpn_datapath.sv =====
`timescale 1ns / 1ps
// Operand stack memory, arithmetic units and output register of the RPN evaluator.
module rpn_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpn_pkg::in_item_t   in_data_i,
  input  rpn_pkg::dp_cmd_t    cmd_i,
  output rpn_pkg::dp_status_t st_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rpn_pkg::out_item_t  out_data_o
);

  logic [rpn_pkg::DATA_W-1:0] stack_mem [rpn_pkg::STACK_DEPTH];

  logic [rpn_pkg::ACT_W-1:0]     act_q;
  logic [rpn_pkg::DATA_W-1:0]    num_q;
  logic [rpn_pkg::SP_W-1:0]      sp_q;
  logic [rpn_pkg::SP_W-1:0]      sp_d;
  logic [rpn_pkg::DATA_W-1:0]    rd_data_q;
  logic [rpn_pkg::ADDR_W-1:0]    rd_addr;
  logic [rpn_pkg::DATA_W-1:0]    top_val;
  logic [rpn_pkg::DATA_W-1:0]    r_q;
  logic [rpn_pkg::DATA_W-1:0]    l_q;
  logic [rpn_pkg::DATA_W-1:0]    mag_l;
  logic [rpn_pkg::DATA_W-1:0]    mag_r;
  logic                          neg;
  logic [2*rpn_pkg::DATA_W-1:0]  prod_q;
  logic [rpn_pkg::DATA_W-1:0]    rem_q;
  logic [rpn_pkg::DATA_W-1:0]    quo_q;
  logic [rpn_pkg::DATA_W-1:0]    dvs_q;
  logic                          ovf_q;
  logic [rpn_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [rpn_pkg::DATA_W:0]      div_trial;
  logic                          div_fit;
  logic [rpn_pkg::DATA_W:0]      div_diff;
  logic [rpn_pkg::DATA_W:0]      sum_add;
  logic [rpn_pkg::DATA_W:0]      sum_sub;
  logic [rpn_pkg::DATA_W-1:0]    op_value;
  logic                          we;
  rpn_pkg::status_e              res_status;
  logic [rpn_pkg::DATA_W-1:0]    res_value;
  logic                          out_valid_q;
  rpn_pkg::out_item_t            out_q;
  logic                          out_free;

  // The read port always follows the top entry; after sp_q settles, the next
  // cycle holds the current top in rd_data_q.
  assign rd_addr = (sp_q == '0) ? '0 : rpn_pkg::ADDR_W'(sp_q - 1'b1);
  assign top_val = (sp_q != '0) ? rd_data_q : '0;

  assign mag_l = rpn_pkg::mag_of(l_q);
  assign mag_r = rpn_pkg::mag_of(r_q);
  assign neg   = l_q[rpn_pkg::DATA_W-1] ^ r_q[rpn_pkg::DATA_W-1];

  assign sum_add = {l_q[rpn_pkg::DATA_W-1], l_q} + {r_q[rpn_pkg::DATA_W-1], r_q};
  assign sum_sub = {l_q[rpn_pkg::DATA_W-1], l_q} - {r_q[rpn_pkg::DATA_W-1], r_q};

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  assign div_trial = {rem_q, quo_q[rpn_pkg::DATA_W-1]};
  assign div_fit   = div_trial >= {1'b0, dvs_q};
  assign div_diff  = div_trial - {1'b0, dvs_q};

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    res_status = rpn_pkg::ST_OK;
    res_value  = '0;
    op_value   = '0;
    sp_d       = sp_q;
    we         = 1'b0;
    case (act_q)
      rpn_pkg::ACT_PUSH: begin
        if (sp_q < rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH)) begin
          op_value  = num_q;
          res_value = num_q;
          we        = 1'b1;
          sp_d      = sp_q + 1'b1;
        end else begin
          res_status = rpn_pkg::ST_FULL;
          sp_d       = '0;
        end
      end
      rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL: begin
        case (act_q)
          rpn_pkg::ACT_ADD: op_value = rpn_pkg::sat_sum(sum_add);
          rpn_pkg::ACT_SUB: op_value = rpn_pkg::sat_sum(sum_sub);
          default: op_value = rpn_pkg::sat_mag(neg,
                              prod_q[2*rpn_pkg::DATA_W-1:rpn_pkg::FRAC_W]);
        endcase
        res_value = op_value;
        we        = 1'b1;
        sp_d      = sp_q + 1'b1;
      end
      rpn_pkg::ACT_DIV: begin
        if (r_q == '0) begin
          res_status = rpn_pkg::ST_ZERODIV;
          sp_d       = '0;
        end else begin
          op_value  = rpn_pkg::sat_mag(neg, ovf_q ? '1 : rpn_pkg::MAG_W'(quo_q));
          res_value = op_value;
          we        = 1'b1;
          sp_d      = sp_q + 1'b1;
        end
      end
      rpn_pkg::ACT_FINISH: begin
        res_value = top_val;
        sp_d      = '0;
      end
      default: begin
        res_status = rpn_pkg::ST_BADOP;
        sp_d       = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && we) begin
      stack_mem[sp_q[rpn_pkg::ADDR_W-1:0]] <= op_value;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        sp_q <= sp_d;
      end else if ((cmd_i.pop_r || cmd_i.pop_l) && sp_q != '0) begin
        sp_q <= sp_q - 1'b1;
      end
      if (cmd_i.div_init) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= in_data_i.action;
      num_q <= in_data_i.number;
    end
    if (cmd_i.pop_r) begin
      r_q <= top_val;
    end
    if (cmd_i.pop_l) begin
      l_q <= top_val;
    end
    if (cmd_i.mul) begin
      prod_q <= mag_l * mag_r;
    end
    if (cmd_i.div_init) begin
      // The quotient fits the word only if the upper dividend half is below the divisor.
      rem_q <= rpn_pkg::DATA_W'(mag_l[rpn_pkg::DATA_W-1:rpn_pkg::FRAC_W]);
      quo_q <= {mag_l[rpn_pkg::FRAC_W-1:0], {(rpn_pkg::DATA_W-rpn_pkg::FRAC_W){1'b0}}};
      dvs_q <= mag_r;
      ovf_q <= rpn_pkg::DATA_W'(mag_l[rpn_pkg::DATA_W-1:rpn_pkg::FRAC_W]) >= mag_r;
    end else if (cmd_i.div_step) begin
      rem_q <= div_fit ? div_diff[rpn_pkg::DATA_W-1:0] : div_trial[rpn_pkg::DATA_W-1:0];
      quo_q <= {quo_q[rpn_pkg::DATA_W-2:0], div_fit};
    end
    if (cmd_i.commit) begin
      out_q.status <= res_status;
      out_q.value  <= res_value;
      out_q.depth  <= rpn_pkg::DEPTH_W'(sp_d);
    end
  end

  assign st_o.action   = act_q;
  assign st_o.r_zero   = (r_q == '0);
  assign st_o.div_last = (cnt_q == rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS - 1));
  assign st_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= rpn_pkg::SP_W'(rpn_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || !out_stall_i))
    else $error("result committed over an untaken result");

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.status == rpn_pkg::ST_OK || out_q.depth == '0))
    else $error("error result with non-empty stack");
`endif

endmodule

// ===== verif/tb_rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the RPN stack evaluator with its own Q16.16 stack predictor.
module tb_rpn_stack_evaluator;

  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 29;

  localparam logic [rpn_pkg::ACT_W-1:0]  ACT_BAD_LO = 3'd6;
  localparam logic [rpn_pkg::ACT_W-1:0]  ACT_BAD_HI = 3'd7;
  localparam logic [rpn_pkg::DATA_W-1:0] ONE_Q      = 32'h0001_0000;
  localparam logic [rpn_pkg::DATA_W-1:0] MINUS_ONE  = 32'hFFFF_0000;
  localparam logic [rpn_pkg::DATA_W-1:0] LSB_Q      = 32'h0000_0001;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  rpn_pkg::in_item_t  in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  rpn_pkg::out_item_t out_data_o;

  rpn_stack_evaluator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: operand stack and entry count.
  logic [rpn_pkg::DATA_W-1:0] calc_stack [rpn_pkg::STACK_DEPTH];
  int unsigned                calc_sp = 0;

  rpn_pkg::out_item_t pending_results [$];
  rpn_pkg::out_item_t want_result;
  int                 mismatch_count = 0;

  logic in_gaps_on  = 1'b0;
  logic out_gaps_on = 1'b0;
  int   hold_seq    = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;

  function automatic logic [rpn_pkg::DATA_W-1:0] calc_pop();
    if (calc_sp == 0) begin
      return '0;
    end
    calc_sp--;
    return calc_stack[calc_sp];
  endfunction

  function automatic logic [rpn_pkg::DATA_W-1:0] clamp_sum(input longint s);
    if (s > 64'sd2147483647) begin
      return rpn_pkg::MAX_POS;
    end else if (s < -64'sd2147483648) begin
      return rpn_pkg::MIN_NEG;
    end
    return s[rpn_pkg::DATA_W-1:0];
  endfunction

  function automatic logic [63:0] abs_word(input logic signed [rpn_pkg::DATA_W-1:0] v);
    longint x;
    x = v;
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic [rpn_pkg::DATA_W-1:0] clamp_to_word(input logic neg,
                                                              input logic [63:0] mag);
    logic [rpn_pkg::DATA_W-1:0] low;
    low = mag[rpn_pkg::DATA_W-1:0];
    if (neg) begin
      return (mag >= 64'h8000_0000) ? rpn_pkg::MIN_NEG : -low;
    end
    return (mag > 64'h7FFF_FFFF) ? rpn_pkg::MAX_POS : low;
  endfunction

  // Applies one token to the predictor stack and returns the result it should produce.
  function automatic rpn_pkg::out_item_t evaluate_token(input rpn_pkg::in_item_t tok);
    rpn_pkg::out_item_t                res;
    logic signed [rpn_pkg::DATA_W-1:0] rhs;
    logic signed [rpn_pkg::DATA_W-1:0] lhs;
    logic [rpn_pkg::DATA_W-1:0]        word;
    logic                              neg;
    res.status = rpn_pkg::ST_OK;
    word = '0;
    case (tok.action)
      rpn_pkg::ACT_ADD, rpn_pkg::ACT_SUB, rpn_pkg::ACT_MUL, rpn_pkg::ACT_DIV: begin
        rhs = calc_pop();
        if (tok.action == rpn_pkg::ACT_DIV && rhs == 0) begin
          res.status = rpn_pkg::ST_ZERODIV;
        end else begin
          lhs = calc_pop();
          neg = lhs[rpn_pkg::DATA_W-1] ^ rhs[rpn_pkg::DATA_W-1];
          case (tok.action)
            rpn_pkg::ACT_ADD: word = clamp_sum(longint'(lhs) + longint'(rhs));
            rpn_pkg::ACT_SUB: word = clamp_sum(longint'(lhs) - longint'(rhs));
            rpn_pkg::ACT_MUL: begin
              word = clamp_to_word(neg, (abs_word(lhs) * abs_word(rhs)) >> rpn_pkg::FRAC_W);
            end
            default: begin
              word = clamp_to_word(neg, (abs_word(lhs) << rpn_pkg::FRAC_W) / abs_word(rhs));
            end
          endcase
          // At least one entry was popped (or the stack was empty), so there is room.
          calc_stack[calc_sp] = word;
          calc_sp++;
        end
      end
      rpn_pkg::ACT_PUSH: begin
        if (calc_sp < rpn_pkg::STACK_DEPTH) begin
          calc_stack[calc_sp] = tok.number;
          calc_sp++;
        end else begin
          res.status = rpn_pkg::ST_FULL;
        end
      end
      rpn_pkg::ACT_FINISH: ;
      default: res.status = rpn_pkg::ST_BADOP;
    endcase
    if (res.status != rpn_pkg::ST_OK) begin
      calc_sp   = 0;
      res.value = '0;
    end else if (tok.action == rpn_pkg::ACT_FINISH) begin
      res.value = calc_pop();
      calc_sp   = 0;
    end else begin
      res.value = (calc_sp == 0) ? '0 : calc_stack[calc_sp-1];
    end
    res.depth = rpn_pkg::DEPTH_W'(calc_sp);
    return res;
  endfunction

  function automatic logic [rpn_pkg::DATA_W-1:0] rand_operand();
    logic [rpn_pkg::DATA_W-1:0] raw;
    raw = $urandom();
    case ($urandom_range(9))
      0, 1, 2: return raw;
      3: begin
        case ($urandom_range(5))
          0: return rpn_pkg::MAX_POS;
          1: return rpn_pkg::MIN_NEG;
          2: return ONE_Q;
          3: return MINUS_ONE;
          4: return LSB_Q;
          default: return '1;
        endcase
      end
      4: return '0;
      5, 6: return rpn_pkg::DATA_W'($signed(raw) >>> $urandom_range(31));
      // Values within plus or minus 4.0 keep products of two such values in range.
      default: return rpn_pkg::DATA_W'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [rpn_pkg::ACT_W-1:0] rand_operator();
    case ($urandom_range(3))
      0: return rpn_pkg::ACT_ADD;
      1: return rpn_pkg::ACT_SUB;
      2: return rpn_pkg::ACT_MUL;
      default: return rpn_pkg::ACT_DIV;
    endcase
  endfunction

  // Offers one token and records its expected result once the transfer completes.
  task automatic send_token(input logic [rpn_pkg::ACT_W-1:0] act,
                            input logic [rpn_pkg::DATA_W-1:0] num);
    rpn_pkg::in_item_t tok;
    tok.action = act;
    tok.number = num;
    while (in_gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= tok;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(evaluate_token(tok));
  endtask

  task automatic stop_offering();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Well-formed expressions with random content, mixed with stray tokens.
  task automatic run_expressions(input int n_items);
    int sent;
    int leaves;
    int pushed;
    int depth_est;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_token(rpn_pkg::ACT_W'($urandom_range(7)), rand_operand());
        sent++;
      end else begin
        leaves    = $urandom_range(1, 6);
        pushed    = 0;
        depth_est = 0;
        while (pushed < leaves || depth_est > 1) begin
          if (pushed < leaves && (depth_est < 2 || $urandom_range(1) == 1)) begin
            send_token(rpn_pkg::ACT_PUSH, rand_operand());
            pushed++;
            depth_est++;
          end else begin
            send_token(rand_operator(), rand_operand());
            depth_est--;
          end
          sent++;
        end
        if ($urandom_range(9) != 0) begin
          send_token(rpn_pkg::ACT_FINISH, $urandom());
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed_tokens();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    send_token(rpn_pkg::ACT_FINISH, '1);
    send_token(rpn_pkg::ACT_ADD, $urandom());
    send_token(rpn_pkg::ACT_PUSH, rpn_pkg::MAX_POS);
    send_token(rpn_pkg::ACT_PUSH, rpn_pkg::MAX_POS);
    send_token(rpn_pkg::ACT_ADD, $urandom());
    send_token(rpn_pkg::ACT_PUSH, rpn_pkg::MIN_NEG);
    send_token(rpn_pkg::ACT_SUB, $urandom());
    send_token(rpn_pkg::ACT_PUSH, rpn_pkg::MIN_NEG);
    send_token(rpn_pkg::ACT_MUL, $urandom());
    send_token(rpn_pkg::ACT_PUSH, MINUS_ONE);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_PUSH, '0);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_PUSH, 32'h0003_8000);
    send_token(rpn_pkg::ACT_PUSH, 32'hFFFE_0000);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_PUSH, LSB_Q);
    send_token(rpn_pkg::ACT_MUL, $urandom());
    send_token(rpn_pkg::ACT_PUSH, '1);
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(ACT_BAD_LO, $urandom());
    send_token(rpn_pkg::ACT_PUSH, ONE_Q);
    send_token(ACT_BAD_HI, '1);
    send_token(rpn_pkg::ACT_SUB, '0);
    send_token(rpn_pkg::ACT_FINISH, $urandom());
  endtask

  task automatic test_full_stack();
    send_token(rpn_pkg::ACT_FINISH, $urandom());
    repeat (rpn_pkg::STACK_DEPTH) send_token(rpn_pkg::ACT_PUSH, rand_operand());
    send_token(rpn_pkg::ACT_PUSH, rand_operand());
    repeat (rpn_pkg::STACK_DEPTH) send_token(rpn_pkg::ACT_PUSH, rand_operand());
    send_token(rpn_pkg::ACT_MUL, $urandom());
    send_token(rpn_pkg::ACT_PUSH, rand_operand());
    send_token(rpn_pkg::ACT_FINISH, $urandom());
  endtask

  // The receiver holds off while tokens keep coming, so the block must stall its input.
  task automatic test_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    hold_seq++;
    repeat (6) send_token(rpn_pkg::ACT_PUSH, rand_operand());
    send_token(rpn_pkg::ACT_DIV, $urandom());
    send_token(rpn_pkg::ACT_MUL, $urandom());
    send_token(rpn_pkg::ACT_ADD, $urandom());
    send_token(rpn_pkg::ACT_SUB, $urandom());
    send_token(rpn_pkg::ACT_PUSH, rand_operand());
    send_token(rpn_pkg::ACT_FINISH, $urandom());
  endtask

  task automatic test_back_to_back();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    run_expressions(40);
  endtask

  task automatic test_random_with_gaps();
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    run_expressions(60);
  endtask

  // Receiver stall: random idling, or a counted hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_seq) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= out_gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  task automatic flag_mismatch(input string what, input rpn_pkg::out_item_t want,
                               input rpn_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s: expected status %0d value %h depth %0d,",
               $time, what, want.status, want.value, want.depth,
               " got status %0d value %h depth %0d",
               got.status, got.value, got.depth);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with none outstanding", '0, out_data_o);
      end else begin
        want_result = pending_results.pop_front();
        if (out_data_o.status !== want_result.status ||
            out_data_o.value  !== want_result.value  ||
            out_data_o.depth  !== want_result.depth) begin
          flag_mismatch("result mismatch", want_result, out_data_o);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tokens();
    test_full_stack();
    test_backpressure();
    test_back_to_back();
    test_random_with_gaps();
    stop_offering();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[rpn_stack_evaluator] OK");
    end else begin
      $display("[rpn_stack_evaluator] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[rpn_stack_evaluator] ERROR");
    $finish;
  end

endmodule
